// ----- src/bsb_pkg.sv -----
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants for the bubble sort buffer.
// ----------------------------------------------------------------------------
package bsb_pkg;

  // Width of one stored element
  localparam int unsigned WORD_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    S_FILL,       // collecting beats
    S_START,      // read entry 0 at the head of the first pass
    S_LOAD,       // load the carried element, read entry 1
    S_STEP,       // one compare and write back per cycle
    S_FLUSH,      // write the carried element at the end of the pass
    S_OUT_START,  // read entry 0 for the output sweep
    S_OUT         // present sorted beats
  } bsb_state_t;

  // Datapath controls from the sequencer
  typedef struct packed {
    logic fill_wr;     // write the incoming value
    logic load_carry;  // carry <= read data
    logic step;        // compare carry with read data, write the smaller
    logic flush;       // write carry
  } bsb_ctl_t;

endpackage

// ----- src/bubble_sort_buffer.sv -----
// ----------------------------------------------------------------------------
// bubble_sort_buffer
// Collects a set of signed words, sorts them ascending, emits them in order.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one signed 32-bit value per beat;
//   in_last_in ends the set. Up to MAX_ELEMENTS values are kept; later
//   values of the set are dropped and the set's results carry out_overflow.
// Output channel (out_valid / out_stall): the stored values in ascending
//   order, one per beat, out_last_out on the final one.
// Between the closing beat and the first result the block runs a bubble
//   sort through one compare unit and one RAM port pair: a pass over entries
//   0..e carries the largest of them up to entry e, each pass one entry
//   shorter, with a start step before the sort and one before the output
//   sweep. Then results follow at one per cycle while the receiver takes
//   them. A single-value set skips the sort.
// in_stall is high from the closing beat until the last result is taken.
// A stalled result holds its payload; sorting never overlaps output.
// Reset empties the buffer and clears the overflow flag; no RAM clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module bubble_sort_buffer
  import bsb_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] in_value_in,
  input  logic                     in_last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic                     out_last_out,
  output logic                     out_overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  bsb_ctl_t                  ctl;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [WORD_W-1:0]         mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [WORD_W-1:0]         mem_rdata;
  logic signed [WORD_W-1:0]  carry_r, carry_nxt;
  logic signed [WORD_W-1:0]  cmp_lo;
  logic signed [WORD_W-1:0]  cmp_hi;

  bsb_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow),
    .ctl          (ctl),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr)
  );

  bsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsb_cmp u_cmp (
    .carry (carry_r),
    .next  (mem_rdata),
    .lo    (cmp_lo),
    .hi    (cmp_hi)
  );

  // RAM write data select
  always_comb begin
    if (ctl.fill_wr) begin
      mem_wdata = in_value_in;
    end else if (ctl.flush) begin
      mem_wdata = carry_r;
    end else begin
      mem_wdata = cmp_lo;
    end
  end

  // Carried element of the running pass
  always_comb begin
    carry_nxt = carry_r;
    if (ctl.load_carry) begin
      carry_nxt = mem_rdata;
    end else if (ctl.step) begin
      carry_nxt = cmp_hi;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  assign out_value_out = mem_rdata;

endmodule

// ----- src/bsb_ram.sv -----
// ----------------------------------------------------------------------------
// bsb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bsb_cmp.sv -----
// ----------------------------------------------------------------------------
// bsb_cmp
// Shared compare unit: orders two signed words, swapping only on strict
// greater-than.
// ----------------------------------------------------------------------------
module bsb_cmp
  import bsb_pkg::*;
(
  input  logic signed [WORD_W-1:0] carry,
  input  logic signed [WORD_W-1:0] next,
  output logic signed [WORD_W-1:0] lo,
  output logic signed [WORD_W-1:0] hi
);

  logic gt;

  // Equal values keep their order
  assign gt = carry > next;
  assign lo = gt ? next  : carry;
  assign hi = gt ? carry : next;

endmodule

// ----- src/bsb_seq.sv -----
// ----------------------------------------------------------------------------
// bsb_seq
// Sequencer: fill count, pass and index counters, RAM addressing and the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module bsb_seq
  import bsb_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_last_out,
  output logic                            out_overflow,
  output bsb_ctl_t                        ctl,
  output logic                            mem_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_waddr,
  output logic                            mem_re,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_raddr
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

  bsb_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_acc;
  logic          out_acc;
  logic          room;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] last_idx;

  assign in_acc    = in_valid && (state_r == S_FILL);
  assign out_acc   = out_valid_r && !out_stall;
  assign room      = count_r < CAP;
  assign count_inc = count_r + CW'(room);
  assign last_idx  = count_r - 1'b1;

  assign in_stall     = (state_r != S_FILL);
  assign out_valid    = out_valid_r;
  assign out_last_out = (k_r == last_idx[AW-1:0]);
  assign out_overflow = ovf_r;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      end_r       <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      end_r       <= end_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state, counters and RAM controls
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    end_nxt       = end_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_FILL: begin
        if (in_acc) begin
          // store while there is room, otherwise drop and flag
          ctl.fill_wr = room;
          mem_we      = room;
          mem_waddr   = count_r[AW-1:0];
          count_nxt   = count_inc;
          if (!room) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_in) begin
            end_nxt = AW'(count_inc - 1'b1);
            if (count_inc == CW'(1)) begin
              state_nxt = S_OUT_START;
            end else begin
              state_nxt = S_START;
            end
          end
        end
      end

      S_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        ctl.load_carry = 1'b1;
        mem_re         = 1'b1;
        mem_raddr      = AW'(1);
        j_nxt          = AW'(1);
        state_nxt      = S_STEP;
      end

      S_STEP: begin
        // smaller of carry and entry j goes to j-1, larger is carried on
        ctl.step  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = j_r - 1'b1;
        if (j_r == end_r) begin
          state_nxt = S_FLUSH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = j_r + 1'b1;
          j_nxt     = j_r + 1'b1;
        end
      end

      S_FLUSH: begin
        ctl.flush = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = end_r;
        if (end_r == AW'(1)) begin
          state_nxt = S_OUT_START;
        end else begin
          // next pass is one shorter; fetch entry 0 now
          end_nxt   = end_r - 1'b1;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_LOAD;
        end
      end

      S_OUT_START: begin
        mem_re        = 1'b1;
        mem_raddr     = '0;
        k_nxt         = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        // read data is the payload; next read only after the beat goes
        if (out_acc) begin
          if (out_last_out) begin
            out_valid_nxt = 1'b0;
            count_nxt     = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_FILL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = k_r + 1'b1;
            k_nxt     = k_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

endmodule

// ----- src/bsb_checker.sv -----
// ----------------------------------------------------------------------------
// bsb_checker
// Port-level checks for the bubble sort buffer, bound to the top level.
// ----------------------------------------------------------------------------
module bsb_checker
  import bsb_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_last_in,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WORD_W-1:0] out_value_out,
  input logic                     out_last_out,
  input logic                     out_overflow
);

  // No input is taken while results are pending
  a_no_fill_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while results pending");

  // Closing beat blocks the input channel
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_in) |=> in_stall)
    else $error("input not stalled after closing beat");

  // Final result ends the output burst
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_out) |=> !out_valid)
    else $error("output valid after final beat");

  // Overflow flag is constant across one set's results
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_out) |=>
      (out_valid && out_overflow == $past(out_overflow)))
    else $error("overflow flag changed within a set");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value_out)))
    else $error("stalled beat changed");

endmodule

bind bubble_sort_buffer bsb_checker u_bsb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_last_in    (in_last_in),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_out (out_value_out),
  .out_last_out  (out_last_out),
  .out_overflow  (out_overflow)
);
